/* hdl/trsmc_pkg.sv */
`timescale 1ns / 1ps

package trsmc_pkg;

    // element widths
    localparam int PW  = 32;        // parent and result elements, Q16.16
    localparam int LW  = 29;        // local matrix elements, Q20
    localparam int CW  = 34;        // signed Q30 working width
    localparam int MW  = 2 * CW;    // product and accumulator width
    localparam int PRW = PW + LW;   // parent times local product
    localparam int SW  = PRW + 2;   // sum of four products

    localparam logic [31:0]    PI_Q30  = 32'd3373259426;
    localparam logic [30:0]    ONE_Q30 = 31'h4000_0000;
    localparam logic [16:0]    TURN    = 17'd23040;
    localparam logic [16:0]    QUART1  = 17'd5760;
    localparam logic [16:0]    QUART2  = 17'd11520;
    localparam logic [16:0]    QUART3  = 17'd17280;
    localparam logic [47:0]    SCALE_RESET = 48'h0100_0100_0100;

    // offset to radians: f * pi / 11520, split into whole and leftover parts
    localparam logic [31:0] X_DEN   = 32'd11520;
    localparam logic [31:0] X_HALF  = X_DEN >> 1;
    localparam logic [18:0] X_INT   = 19'(PI_Q30 / X_DEN);
    localparam logic [13:0] X_FRAC  = 14'(PI_Q30 % X_DEN);
    // ceil(2^40 / 11520), exact floor for leftover numerators below 2^26
    localparam logic [26:0] X_RECIP = 27'((64'd1 << 40) / 64'(X_DEN) + 64'd1);
    localparam logic [5:0]  X_SHIFT = 6'd40;

    typedef enum logic [1:0] {
        CFG_POSITION = 2'd0,
        CFG_ROTATION = 2'd1,
        CFG_SCALE    = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG,
        ST_XMUL,
        ST_XDIV,
        ST_X2MUL,
        ST_NMUL,
        ST_NDIV,
        ST_SMUL,
        ST_STORE,
        ST_RMAC,
        ST_RSTORE,
        ST_SCALE
    } seq_state_t;

    typedef logic signed [LW-1:0] lelem_t;
    typedef lelem_t [2:0][2:0] lmat_t;

    typedef struct packed {
        logic [5:0]  shift;
        logic [32:0] mul;
    } recip_t;

    typedef struct packed {
        logic signed [PW-1:0] parent_row_e3;
        logic signed [PW-1:0] parent_row_e2;
        logic signed [PW-1:0] parent_row_e1;
        logic signed [PW-1:0] parent_row_e0;
    } parent_row_t;

    typedef struct packed {
        logic signed [PW-1:0] result_row_e3;
        logic signed [PW-1:0] result_row_e2;
        logic signed [PW-1:0] result_row_e1;
        logic signed [PW-1:0] result_row_e0;
        logic                 saturated;
    } result_row_t;

    // signed 16-bit lane k of a packed xyz register
    function automatic logic signed [15:0] lane16(input logic [47:0] w, input logic [1:0] k);
        logic signed [15:0] v;
        case (k)
            2'd0:    v = $signed(w[15:0]);
            2'd1:    v = $signed(w[31:16]);
            2'd2:    v = $signed(w[47:32]);
            default: v = '0;
        endcase
        return v;
    endfunction

    // round to nearest, halves away from zero, then shift right by n
    function automatic logic signed [MW-1:0] rnd_shift(input logic signed [MW-1:0] v,
                                                       input int unsigned n);
        logic [MW-1:0] mag;
        logic [MW-1:0] r;
        mag = v[MW-1] ? MW'(-v) : MW'(v);
        r   = (mag + (MW'(1) << (n - 1))) >> n;
        return v[MW-1] ? -$signed(r) : $signed(r);
    endfunction

    // reciprocals of the nested series divisors, innermost first
    // ceil(2^shift / d), exact floor for any 32-bit numerator
    function automatic recip_t nest_recip(input logic is_cos, input logic [2:0] step);
        recip_t r;
        if (is_cos)
        begin
            case (step)
                3'd0:    r = '{6'd40, 33'd8329633544};   // 132
                3'd1:    r = '{6'd39, 33'd6108397933};   // 90
                3'd2:    r = '{6'd38, 33'd4908534053};   // 56
                3'd3:    r = '{6'd37, 33'd4581298450};   // 30
                3'd4:    r = '{6'd36, 33'd5726623062};   // 12
                default: r = '{6'd33, 33'd4294967296};   // 2
            endcase
        end
        else
        begin
            case (step)
                3'd0:    r = '{6'd39, 33'd4997780127};   // 110
                3'd1:    r = '{6'd39, 33'd7635497416};   // 72
                3'd2:    r = '{6'd38, 33'd6544712071};   // 42
                3'd3:    r = '{6'd37, 33'd6871947674};   // 20
                default: r = '{6'd35, 33'd5726623062};   // 6
            endcase
        end
        return r;
    endfunction

endpackage

/* hdl/trsmc_local.sv */
`timescale 1ns / 1ps

module trsmc_local
    import trsmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restart,
    input  logic [47:0] rotation_xyz,
    input  logic [47:0] scale_xyz,
    output logic        busy,
    output lmat_t       lmat
);

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    seq_state_t state_reg, state_next;

    logic [1:0] ang_reg;
    logic       is_cos_reg;
    logic [2:0] step_reg;
    logic       pass_reg;
    logic [1:0] i_reg, j_reg, k_reg;

    logic [1:0]  q_reg;
    logic [12:0] f_reg;
    logic [31:0] x_reg, x2_reg, sv_reg;
    logic [30:0] t_reg;
    logic [31:0] num_reg;

    logic signed [CW-1:0] sin_reg [3];
    logic signed [CW-1:0] cos_reg [3];
    logic signed [CW-1:0] tmp_reg [3][3];
    logic signed [CW-1:0] rot_reg [3][3];
    logic signed [MW-1:0] acc_reg;
    lelem_t               lm_reg  [3][3];

    logic signed [15:0] ang_lane;
    logic [16:0]        ang_red;
    logic [1:0]         ang_q;
    logic [12:0]        ang_f;

    recip_t         nrecip;
    logic [5:0]     div_shift;
    logic [31:0]    quot;
    logic [31:0]    x_int;
    logic [30:0]    t_new;
    logic [2:0]     last_step;

    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [MW-1:0] mul_p, x2_full;
    logic signed [CW-1:0] sv_s, cv_s;

    function automatic logic signed [CW-1:0] rot_elem(input logic [1:0] axis,
                                                      input logic [1:0] r,
                                                      input logic [1:0] c,
                                                      input logic signed [CW-1:0] s,
                                                      input logic signed [CW-1:0] cv);
        logic signed [CW-1:0] one;
        logic signed [CW-1:0] e;
        one = CW'(ONE_Q30);
        e   = '0;
        case (axis)
            AX_X: begin
                case ({r, c})
                    4'b0000: e = one;
                    4'b0101: e = cv;
                    4'b0110: e = -s;
                    4'b1001: e = s;
                    4'b1010: e = cv;
                    default: e = '0;
                endcase
            end
            AX_Y: begin
                case ({r, c})
                    4'b0000: e = cv;
                    4'b0010: e = s;
                    4'b0101: e = one;
                    4'b1000: e = -s;
                    4'b1010: e = cv;
                    default: e = '0;
                endcase
            end
            default: begin
                case ({r, c})
                    4'b0000: e = cv;
                    4'b0001: e = -s;
                    4'b0100: e = s;
                    4'b0101: e = cv;
                    4'b1010: e = one;
                    default: e = '0;
                endcase
            end
        endcase
        return e;
    endfunction

    // angle wrap, quadrant and offset
    always_comb
    begin
        ang_lane = lane16(rotation_xyz, ang_reg);
        ang_red  = 17'($signed({{16{ang_lane[15]}}, ang_lane}) + 32'sd46080);
        for (int n = 0; n < 3; n++)
        begin
            if (ang_red >= TURN)
                ang_red = ang_red - TURN;
        end
        if (ang_red >= QUART3)
        begin
            ang_q = 2'd3;
            ang_f = 13'(ang_red - QUART3);
        end
        else if (ang_red >= QUART2)
        begin
            ang_q = 2'd2;
            ang_f = 13'(ang_red - QUART2);
        end
        else if (ang_red >= QUART1)
        begin
            ang_q = 2'd1;
            ang_f = 13'(ang_red - QUART1);
        end
        else
        begin
            ang_q = 2'd0;
            ang_f = 13'(ang_red);
        end
    end

    assign nrecip = nest_recip(is_cos_reg, step_reg);

    // division by reciprocal multiplication, quotient taken from the shared product
    always_comb
    begin
        div_shift = (state_reg == ST_XDIV) ? X_SHIFT : nrecip.shift;
        quot      = 32'($unsigned(mul_p) >> div_shift);
        t_new     = (quot > {1'b0, ONE_Q30}) ? '0 : ONE_Q30 - quot[30:0];
        last_step = is_cos_reg ? 3'd5 : 3'd4;
        x_int     = 32'(f_reg) * 32'(X_INT);
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_XMUL:
            begin
                mul_a = CW'(f_reg);
                mul_b = CW'(X_FRAC);
            end
            ST_XDIV:
            begin
                mul_a = CW'(num_reg);
                mul_b = CW'(X_RECIP);
            end
            ST_X2MUL:
            begin
                mul_a = CW'(x_reg);
                mul_b = CW'(x_reg);
            end
            ST_NMUL:
            begin
                mul_a = CW'(x2_reg);
                mul_b = CW'(t_reg);
            end
            ST_NDIV:
            begin
                mul_a = CW'(num_reg);
                mul_b = CW'(nrecip.mul);
            end
            ST_SMUL:
            begin
                mul_a = CW'(x_reg);
                mul_b = CW'(t_reg);
            end
            ST_RMAC:
            begin
                if (pass_reg)
                begin
                    mul_a = tmp_reg[i_reg][k_reg];
                    mul_b = rot_elem(AX_Z, k_reg, j_reg, sin_reg[2], cos_reg[2]);
                end
                else
                begin
                    mul_a = rot_elem(AX_Y, i_reg, k_reg, sin_reg[1], cos_reg[1]);
                    mul_b = rot_elem(AX_X, k_reg, j_reg, sin_reg[0], cos_reg[0]);
                end
            end
            ST_SCALE:
            begin
                mul_a = rot_reg[i_reg][j_reg];
                mul_b = CW'(lane16(scale_xyz, j_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = mul_a * mul_b;
        x2_full = mul_p + MW'(64'd1 << 29);
        busy    = (state_reg != ST_IDLE);
        sv_s    = CW'(sv_reg);
        cv_s    = CW'(t_reg);
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                lmat[r][c] = lm_reg[r][c];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (restart)
            state_next = ST_ANG;
        else
        begin
            case (state_reg)
                ST_IDLE:  state_next = ST_IDLE;
                ST_ANG:   state_next = ST_XMUL;
                ST_XMUL:  state_next = ST_XDIV;
                ST_XDIV:  state_next = ST_X2MUL;
                ST_X2MUL: state_next = ST_NMUL;
                ST_NMUL:  state_next = ST_NDIV;
                ST_NDIV:
                begin
                    if (step_reg == last_step)
                        state_next = is_cos_reg ? ST_STORE : ST_SMUL;
                    else
                        state_next = ST_NMUL;
                end
                ST_SMUL:  state_next = ST_NMUL;
                ST_STORE: state_next = (ang_reg == 2'd2) ? ST_RMAC : ST_ANG;
                ST_RMAC:  state_next = (k_reg == 2'd2) ? ST_RSTORE : ST_RMAC;
                ST_RSTORE:
                begin
                    if (i_reg == 2'd2 && j_reg == 2'd2)
                        state_next = pass_reg ? ST_SCALE : ST_RMAC;
                    else
                        state_next = ST_RMAC;
                end
                ST_SCALE:
                    state_next = (i_reg == 2'd2 && j_reg == 2'd2) ? ST_IDLE : ST_SCALE;
                default:  state_next = ST_IDLE;
            endcase
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ANG;
            ang_reg     <= '0;
            is_cos_reg  <= 1'b0;
            step_reg    <= '0;
            pass_reg    <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
                ang_reg <= '0;
            else
            begin
                case (state_reg)
                    ST_NDIV:
                    begin
                        if (step_reg != last_step)
                            step_reg <= step_reg + 3'd1;
                    end
                    ST_X2MUL:
                    begin
                        is_cos_reg <= 1'b0;
                        step_reg   <= '0;
                    end
                    ST_SMUL:
                    begin
                        is_cos_reg <= 1'b1;
                        step_reg   <= '0;
                    end
                    ST_STORE:
                    begin
                        if (ang_reg == 2'd2)
                        begin
                            pass_reg <= 1'b0;
                            i_reg    <= '0;
                            j_reg    <= '0;
                            k_reg    <= '0;
                        end
                        else
                            ang_reg <= ang_reg + 2'd1;
                    end
                    ST_RMAC:
                    begin
                        if (k_reg != 2'd2)
                            k_reg <= k_reg + 2'd1;
                    end
                    ST_RSTORE, ST_SCALE:
                    begin
                        k_reg <= '0;
                        if (j_reg == 2'd2)
                        begin
                            j_reg <= '0;
                            if (i_reg == 2'd2)
                            begin
                                i_reg    <= '0;
                                pass_reg <= 1'b1;
                            end
                            else
                                i_reg <= i_reg + 2'd1;
                        end
                        else
                            j_reg <= j_reg + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_ANG:
            begin
                q_reg <= ang_q;
                f_reg <= ang_f;
            end
            ST_XMUL:
            begin
                // leftover part of f * pi plus half of the divisor for rounding
                num_reg <= mul_p[31:0] + X_HALF;
                x_reg   <= x_int;
            end
            ST_XDIV:
                x_reg <= x_reg + quot;
            ST_X2MUL:
            begin
                x2_reg <= x2_full[61:30];
                t_reg  <= ONE_Q30;
            end
            ST_NMUL:
                num_reg <= mul_p[61:30];
            ST_NDIV:
                t_reg <= t_new;
            ST_SMUL:
            begin
                sv_reg <= mul_p[61:30];
                t_reg  <= ONE_Q30;
            end
            ST_STORE:
            begin
                case (q_reg)
                    2'd0:
                    begin
                        sin_reg[ang_reg] <= sv_s;
                        cos_reg[ang_reg] <= cv_s;
                    end
                    2'd1:
                    begin
                        sin_reg[ang_reg] <= cv_s;
                        cos_reg[ang_reg] <= -sv_s;
                    end
                    2'd2:
                    begin
                        sin_reg[ang_reg] <= -sv_s;
                        cos_reg[ang_reg] <= -cv_s;
                    end
                    default:
                    begin
                        sin_reg[ang_reg] <= -cv_s;
                        cos_reg[ang_reg] <= sv_s;
                    end
                endcase
                acc_reg <= '0;
            end
            ST_RMAC:
                acc_reg <= acc_reg + mul_p;
            ST_RSTORE:
            begin
                if (pass_reg)
                    rot_reg[i_reg][j_reg] <= CW'(rnd_shift(acc_reg, 30));
                else
                    tmp_reg[i_reg][j_reg] <= CW'(rnd_shift(acc_reg, 30));
                acc_reg <= '0;
            end
            ST_SCALE:
                lm_reg[i_reg][j_reg] <= LW'(rnd_shift(mul_p, 18));
            default:
            begin
            end
        endcase
    end

endmodule

/* hdl/trs_model_matrix_row_compose.sv */
`timescale 1ns / 1ps
// an accepted parent row passes the product, column-sum and output registers on its way to its result row
// throughput: one row per cycle, stalls on the result side propagate back
// after reset and after any write of rotation or scale, the local matrix is rebuilt
// by a sequencer (sine and cosine series per angle, the rotation product, then scale),
// parent_ready stays low meanwhile; position writes take effect at once
// reset: asynchronous active low, clears pipeline valids, config to zero and unit scale

module trs_model_matrix_row_compose
    import trsmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        parent_valid,
    output logic        parent_ready,
    input  parent_row_t parent_row,
    output logic        result_valid,
    input  logic        result_ready,
    output result_row_t result_row
);

    // configuration registers
    logic [47:0] position_reg, rotation_reg, scale_reg;
    logic        restart;

    // local matrix builder
    logic  lm_busy;
    lmat_t lmat;

    // full 4x4 local matrix in Q20 and the incoming row
    lelem_t               lfull [4][4];
    logic signed [PW-1:0] p     [4];

    // pipeline: products, column sums, rounded and saturated result
    logic                  a_valid_reg, b_valid_reg, c_valid_reg;
    logic                  a_ready, b_ready, c_ready;
    logic                  in_fire;
    logic signed [PRW-1:0] prod_a_reg [4][4];
    logic signed [SW-1:0]  sum_b_reg  [4];
    result_row_t           res_c_reg;
    result_row_t           res_c_next;

    assign cfg_ready = 1'b1;

    // only rotation and scale feed the rebuilt part of the matrix
    assign restart = cfg_valid && (cfg_index == CFG_ROTATION || cfg_index == CFG_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            rotation_reg <= '0;
            scale_reg    <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POSITION: position_reg <= cfg_data;
                CFG_ROTATION: rotation_reg <= cfg_data;
                CFG_SCALE:    scale_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    trsmc_local u_local (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .rotation_xyz (rotation_reg),
        .scale_xyz    (scale_reg),
        .busy         (lm_busy),
        .lmat         (lmat)
    );

    // rotation-scale block, translation column, fixed bottom row
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                lfull[r][c] = lmat[r][c];
            lfull[r][3] = LW'(lane16(position_reg, 2'(r))) <<< 12;
        end
        lfull[3][0] = '0;
        lfull[3][1] = '0;
        lfull[3][2] = '0;
        lfull[3][3] = LW'(1) <<< 20;
    end

    assign p[0] = parent_row.parent_row_e0;
    assign p[1] = parent_row.parent_row_e1;
    assign p[2] = parent_row.parent_row_e2;
    assign p[3] = parent_row.parent_row_e3;

    // ready chain, each stage moves when the one after it can take
    assign c_ready      = !c_valid_reg || result_ready;
    assign b_ready      = !b_valid_reg || c_ready;
    assign a_ready      = !a_valid_reg || b_ready;
    assign parent_ready = a_ready && !lm_busy;
    assign in_fire      = parent_valid && parent_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_fire;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    // round to Q16.16 and clip each column
    always_comb
    begin
        logic signed [MW-1:0] v;
        logic [PW-1:0]        e [4];
        logic                 sat;
        sat = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            v = rnd_shift(MW'(sum_b_reg[j]), 20);
            if (&v[MW-1:PW-1] || ~|v[MW-1:PW-1])
                e[j] = v[PW-1:0];
            else
            begin
                e[j] = v[MW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
                sat  = 1'b1;
            end
        end
        res_c_next.result_row_e0 = $signed(e[0]);
        res_c_next.result_row_e1 = $signed(e[1]);
        res_c_next.result_row_e2 = $signed(e[2]);
        res_c_next.result_row_e3 = $signed(e[3]);
        res_c_next.saturated     = sat;
    end

    always_ff @(posedge clk)
    begin
        // stage a: sixteen products of the row with the local matrix
        if (in_fire)
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int j = 0; j < 4; j++)
                    prod_a_reg[k][j] <= PRW'(p[k]) * PRW'(lfull[k][j]);
            end
        end
        // stage b: column sums
        if (b_ready && a_valid_reg)
        begin
            for (int j = 0; j < 4; j++)
                sum_b_reg[j] <= SW'(prod_a_reg[0][j]) + SW'(prod_a_reg[1][j])
                              + SW'(prod_a_reg[2][j]) + SW'(prod_a_reg[3][j]);
        end
        // stage c: output register
        if (c_ready && b_valid_reg)
            res_c_reg <= res_c_next;
    end

    assign result_valid = c_valid_reg;
    assign result_row   = res_c_reg;

endmodule

/* test/trs_model_matrix_row_compose_tb.sv */
`timescale 1ns / 1ps

module trs_model_matrix_row_compose_tb;
    import trsmc_pkg::*;

    // register index that the block must ignore
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // cycles without any handshake before the run is declared hung; covers the
    // matrix rebuild after a rotation or scale write plus the long receiver hold
    localparam int HANG_LIMIT = 8000;
    localparam int LONG_HOLD  = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        parent_valid;
    logic        parent_ready;
    parent_row_t parent_row;
    logic        result_valid;
    logic        result_ready;
    result_row_t result_row;

    // testbench copy of the three transform registers
    logic [47:0] pos_shadow;
    logic [47:0] rot_shadow;
    logic [47:0] scl_shadow;

    // composed rows still owed by the block, oldest first
    result_row_t owed_rows[$];

    int  mismatches;
    int  rows_sent;
    int  rows_checked;
    int  cfg_writes;
    int  sat_rows;
    int  idle_cycles;
    bit  quiet;        // no gaps on either side while set
    bit  long_hold;    // receiver request for one long stall

    typedef struct {
        parent_row_t row;
        bit          typed;
        result_row_t want;
    } row_case_t;

    row_case_t directed[$];

    trs_model_matrix_row_compose dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .parent_valid (parent_valid),
        .parent_ready (parent_ready),
        .parent_row   (parent_row),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_row   (result_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // fixed-point predictor of the composed row
    // ------------------------------------------------------------------

    // round half away from zero, then drop n fraction bits
    function automatic longint round_shr(input longint v, input int n);
        longint h;
        h = longint'(1) <<< (n - 1);
        if (v >= 0)
            return (v + h) >>> n;
        return -((-v + h) >>> n);
    endfunction

    // divisor of series term i, innermost term first
    function automatic longint unsigned series_div(input bit cosine, input int i);
        longint unsigned d;
        if (cosine)
            case (i)
                0: d = 132;
                1: d = 90;
                2: d = 56;
                3: d = 30;
                4: d = 12;
                default: d = 2;
            endcase
        else
            case (i)
                0: d = 110;
                1: d = 72;
                2: d = 42;
                3: d = 20;
                default: d = 6;
            endcase
        return d;
    endfunction

    // Horner form of the truncated series in unsigned Q30, clamped at zero
    function automatic longint unsigned series_q30(input longint unsigned x2, input bit cosine);
        longint unsigned t;
        longint unsigned p;
        int n;
        t = 64'd1 << 30;
        n = cosine ? 6 : 5;
        for (int i = 0; i < n; i++)
        begin
            p = ((x2 * t) >> 30) / series_div(cosine, i);
            t = (p > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - p;
        end
        return t;
    endfunction

    // sine and cosine in Q30 of an angle in 1/64 degree
    function automatic void angle_trig(input logic signed [15:0] ang,
                                       output longint s, output longint c);
        longint unsigned r;
        longint unsigned quad;
        longint unsigned off;
        longint unsigned x;
        longint unsigned x2;
        longint sv;
        longint cv;
        r    = longint'(ang) + 64'd46080;
        r    = r % 64'd23040;
        quad = r / 64'd5760;
        off  = r % 64'd5760;
        x    = (off * 64'd3373259426 + 64'd5760) / 64'd11520;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        sv   = longint'((x * series_q30(x2, 1'b0)) >> 30);
        cv   = longint'(series_q30(x2, 1'b1));
        case (quad)
            0: begin s = sv;  c = cv;  end
            1: begin s = cv;  c = -sv; end
            2: begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv; end
        endcase
    endfunction

    function automatic result_row_t compose_row(input parent_row_t pr);
        longint sx, cx, sy, cy, sz, cz;
        longint ry[3][3];
        longint rx[3][3];
        longint rz[3][3];
        longint ryx[3][3];
        longint rot[3][3];
        longint lm[4][4];
        longint pe[4];
        longint acc;
        longint v;
        longint one;
        logic [31:0] o[4];
        result_row_t res;
        one = longint'(1) <<< 30;
        angle_trig(rot_shadow[15:0],  sx, cx);
        angle_trig(rot_shadow[31:16], sy, cy);
        angle_trig(rot_shadow[47:32], sz, cz);

        ry = '{'{cy, 0, sy}, '{0, one, 0}, '{-sy, 0, cy}};
        rx = '{'{one, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, one}};

        // rotation order y, x, z; each element rounded back to Q30
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += ry[i][k] * rx[k][j];
                ryx[i][j] = round_shr(acc, 30);
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += ryx[i][k] * rz[k][j];
                rot[i][j] = round_shr(acc, 30);
            end

        // local matrix in Q20: scaled columns, translation in the last column
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                lm[r][c] = round_shr(rot[r][c] *
                                     longint'($signed(scl_shadow[16*c +: 16])), 18);
            lm[r][3] = longint'($signed(pos_shadow[16*r +: 16])) * 4096;
        end
        lm[3] = '{0, 0, 0, longint'(1) <<< 20};

        pe[0] = longint'(pr.parent_row_e0);
        pe[1] = longint'(pr.parent_row_e1);
        pe[2] = longint'(pr.parent_row_e2);
        pe[3] = longint'(pr.parent_row_e3);

        res.saturated = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += pe[k] * lm[k][j];
            v = round_shr(acc, 20);
            if (v > 64'sd2147483647)
            begin
                v = 64'sd2147483647;
                res.saturated = 1'b1;
            end
            else if (v < -64'sd2147483648)
            begin
                v = -64'sd2147483648;
                res.saturated = 1'b1;
            end
            o[j] = v[31:0];
        end
        res.result_row_e0 = o[0];
        res.result_row_e1 = o[1];
        res.result_row_e2 = o[2];
        res.result_row_e3 = o[3];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request drivers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // one parent row request; valid stays high when the next row follows at once
    task automatic send_row(input parent_row_t row, input bit typed, input result_row_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            parent_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        parent_valid <= 1'b1;
        parent_row   <= row;
        do @(negedge clk); while (!parent_ready);
        // config is frozen while rows flow, so the prediction is taken now
        owed_rows.push_back(typed ? want : compose_row(row));
        rows_sent++;
        @(posedge clk);
    endtask

    // register write; only issued while no row is in flight
    task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        case (idx)
            CFG_POSITION: pos_shadow = data;
            CFG_ROTATION: rot_shadow = data;
            CFG_SCALE:    scl_shadow = data;
            default: ;    // unused index leaves all registers alone
        endcase
        cfg_writes++;
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering rows and wait for every owed result
    task automatic settle();
        parent_valid <= 1'b0;
        while (owed_rows.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_lane();
        case ($urandom_range(0, 6))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h0100;
            4: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_elem();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            3: return 32'h0000_0000;
            4, 5: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic parent_row_t pick_row();
        parent_row_t r;
        r.parent_row_e0 = pick_elem();
        r.parent_row_e1 = pick_elem();
        r.parent_row_e2 = pick_elem();
        // half the rows affine: last column zero or one, the rest random
        case ($urandom_range(0, 3))
            0: r.parent_row_e3 = 32'h0000_0000;
            1: r.parent_row_e3 = 32'h0001_0000;
            default: r.parent_row_e3 = pick_elem();
        endcase
        return r;
    endfunction

    function automatic row_case_t typed_case(input logic [31:0] e0, input logic [31:0] e1,
                                             input logic [31:0] e2, input logic [31:0] e3,
                                             input logic [31:0] w0, input logic [31:0] w1,
                                             input logic [31:0] w2, input logic [31:0] w3,
                                             input logic ws);
        row_case_t t;
        t.row   = '{e3, e2, e1, e0};
        t.typed = 1'b1;
        t.want  = '{w3, w2, w1, w0, ws};
        return t;
    endfunction

    function automatic row_case_t plain_case(input logic [31:0] e0, input logic [31:0] e1,
                                             input logic [31:0] e2, input logic [31:0] e3);
        row_case_t t;
        t.row   = '{e3, e2, e1, e0};
        t.typed = 1'b0;
        t.want  = '0;
        return t;
    endfunction

    task automatic run_table(input int first, input int last);
        for (int i = first; i <= last; i++)
            send_row(directed[i].row, directed[i].typed, directed[i].want);
        settle();
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(negedge clk); while (!result_valid);
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // result checker and hang watchdog, sampled mid-cycle
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (owed_rows.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result row with nothing outstanding", $time);
                end
                else
                begin : compare
                    result_row_t w;
                    w = owed_rows.pop_front();
                    rows_checked++;
                    if (w.saturated)
                        sat_rows++;
                    if (result_row.result_row_e0 !== w.result_row_e0)
                        report_mismatch("result_row_e0", result_row.result_row_e0,
                                        w.result_row_e0);
                    if (result_row.result_row_e1 !== w.result_row_e1)
                        report_mismatch("result_row_e1", result_row.result_row_e1,
                                        w.result_row_e1);
                    if (result_row.result_row_e2 !== w.result_row_e2)
                        report_mismatch("result_row_e2", result_row.result_row_e2,
                                        w.result_row_e2);
                    if (result_row.result_row_e3 !== w.result_row_e3)
                        report_mismatch("result_row_e3", result_row.result_row_e3,
                                        w.result_row_e3);
                    if (result_row.saturated !== w.saturated)
                        report_mismatch("saturated", 32'(result_row.saturated),
                                        32'(w.saturated));
                end
            end

            if ((result_valid && result_ready) || (parent_valid && parent_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, HANG_LIMIT);
                $display("trs_model_matrix_row_compose_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_POSITION;
        cfg_data     = '0;
        parent_valid = 1'b0;
        parent_row   = '0;
        mismatches   = 0;
        rows_sent    = 0;
        rows_checked = 0;
        cfg_writes   = 0;
        sat_rows     = 0;
        idle_cycles  = 0;
        quiet        = 1'b0;
        long_hold    = 1'b0;
        pos_shadow   = '0;
        rot_shadow   = '0;
        scl_shadow   = SCALE_RESET;

        // reset values give an identity local matrix: rows pass straight through
        directed.push_back(typed_case(32'h0001_0000, 0, 0, 0,
                                      32'h0001_0000, 0, 0, 0, 1'b0));
        directed.push_back(typed_case(0, 32'h0001_0000, 0, 0,
                                      0, 32'h0001_0000, 0, 0, 1'b0));
        directed.push_back(typed_case(0, 0, 0, 32'h0001_0000,
                                      0, 0, 0, 32'h0001_0000, 1'b0));
        directed.push_back(typed_case(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                      1'b0));
        directed.push_back(typed_case(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                                      32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                                      1'b0));
        // index 5..7: largest scale, unrotated; the diagonal overflows
        directed.push_back(typed_case(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1'b1));
        directed.push_back(typed_case(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1'b1));
        directed.push_back(plain_case(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000));
        // index 8..13: angles past a full turn, mirrored scale, translation extremes
        directed.push_back(plain_case(32'h0001_0000, 0, 0, 0));
        directed.push_back(plain_case(0, 32'h0001_0000, 0, 0));
        directed.push_back(plain_case(0, 0, 32'h0001_0000, 0));
        directed.push_back(plain_case(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                      32'h0001_0000));
        directed.push_back(plain_case(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        directed.push_back(plain_case(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        // index 14..16: zero scale collapses the matrix to translation only
        directed.push_back(plain_case(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'h0001_0000));
        directed.push_back(plain_case(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        directed.push_back(plain_case(0, 0, 0, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity after reset
        run_table(0, 4);

        write_reg(CFG_SCALE, 48'h7FFF_7FFF_7FFF);
        run_table(5, 7);

        // quarter turn on x, most negative y, z beyond a full turn, mirrored scale
        write_reg(CFG_ROTATION, 48'h7FFF_8000_1680);
        write_reg(CFG_SCALE, 48'h8000_FF00_0100);
        write_reg(CFG_POSITION, 48'h8000_7FFF_0100);
        write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
        run_table(8, 13);

        write_reg(CFG_SCALE, 48'h0000_0000_0000);
        run_table(14, 16);

        // random phases: new settings, then a burst of rows
        for (phase = 0; phase < 14; phase++)
        begin
            if (phase == 0)
            begin
                write_reg(CFG_POSITION, 48'h0);
                write_reg(CFG_ROTATION, 48'h0);
                write_reg(CFG_SCALE, SCALE_RESET);
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_POSITION, {pick_lane(), pick_lane(), pick_lane()});
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_ROTATION, {16'($urandom), 16'($urandom), 16'($urandom)});
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_SCALE, {pick_lane(), pick_lane(), pick_lane()});
                if ($urandom_range(0, 5) == 0)
                    write_reg(CFG_UNUSED, {16'($urandom), 16'($urandom), 16'($urandom)});
            end

            // back-to-back stretches on both sides every third phase
            quiet = (phase % 3 == 2);
            // receiver parks while rows keep coming, so the pipe backs up
            if (phase == 4)
                long_hold = 1'b1;

            repeat (100)
                send_row(pick_row(), 1'b0, '0);
            settle();
        end
        quiet = 1'b0;

        repeat (20) @(posedge clk);
        if (owed_rows.size() != 0)
        begin
            mismatches++;
            $display("%0d result rows never arrived", owed_rows.size());
        end

        $display("covered %0d parent rows, %0d results compared, %0d with clipping",
                 rows_sent, rows_checked, sat_rows);
        $display("%0d register writes across reset, extreme and random transforms",
                 cfg_writes);
        if (mismatches == 0)
            $display("trs_model_matrix_row_compose_tb: PASS");
        else
            $display("trs_model_matrix_row_compose_tb: FAIL");
        $finish;
    end

endmodule
